// ===== design/csr_sparse_matrix_vector_multiply_top_assert.svh =====
// Assertion macros shared by the checker of the sparse matrix-vector block.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CSRSPMV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csrspmv check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CSRSPMV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csrspmv check failed");

`endif

// ===== design/csrspmv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csrspmv_pkg;

    localparam int unsigned DEF_VECTOR_DEPTH = 1024;
    localparam int unsigned DEF_MAX_ROWS     = 65536;

    localparam int unsigned OFIFO_DEPTH = 8;
    localparam int unsigned OFIFO_PW    = $clog2(OFIFO_DEPTH);

    localparam logic [1:0] REG_FIRST_ROW   = 2'd0;
    localparam logic [1:0] REG_ROW_LIMIT   = 2'd1;
    localparam logic [1:0] REG_COLS_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE_VEC = 2'd0,
        CMD_NONZERO   = 2'd1,
        CMD_EMPTY_ROW = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic [15:0]        row_number;
        logic [9:0]         column;
        logic signed [31:0] entry_value;
        logic               row_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        result_index;
        logic signed [31:0] result_value;
        logic               overflow;
        logic               batch_done;
    } t_out_item;

    typedef struct packed {
        logic        add;
        logic        closes;
        logic        is_nz;
        logic        emit;
        logic [15:0] index;
        logic        batch_done;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== design/csrspmv_vmem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_vmem import csrspmv_pkg::*; #(
    parameter int unsigned VECTOR_DEPTH = DEF_VECTOR_DEPTH,
    localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [31:0]   i_wdata,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [VECTOR_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/csrspmv_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_mac import csrspmv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_ctrl              i_ctrl,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [31:0] i_vec,
    output logic                    o_push,
    output t_out_item               o_result,
    output logic [1:0]              o_inflight
);

    localparam logic signed [63:0] ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] RND_HALF = 64'sh8000;

    logic               r_s1_valid;
    t_ctrl              r_s1_ctrl;
    logic signed [31:0] r_s1_value;

    logic               r_s2_valid;
    t_ctrl              r_s2_ctrl;
    logic signed [63:0] r_s2_prod;

    logic               r_s3_emit;
    logic [15:0]        r_s3_index;
    logic               r_s3_bd;
    logic signed [63:0] r_s3_res;

    logic signed [63:0] r_acc;

    logic signed [63:0] n_acc;
    logic signed [63:0] w_addend;
    logic signed [64:0] w_sum65;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_res;
    logic signed [63:0] w_rnd;
    logic signed [63:0] w_shift;
    logic               w_ovf;

    always_comb begin
        w_addend = r_s2_ctrl.add ? r_s2_prod : '0;
        w_sum65  = {r_acc[63], r_acc} + {w_addend[63], w_addend};
        if (w_sum65[64] != w_sum65[63]) begin
            w_sum = w_sum65[64] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sum = w_sum65[63:0];
        end
        w_res = r_s2_ctrl.is_nz ? w_sum : '0;
        n_acc = r_acc;
        if (r_s2_valid) begin
            n_acc = r_s2_ctrl.closes ? '0 : w_sum;
        end
    end

    always_comb begin
        w_rnd   = (r_s3_res > (ACC_MAX - RND_HALF)) ? ACC_MAX : (r_s3_res + RND_HALF);
        w_shift = w_rnd >>> 16;
        w_ovf   = !((&w_shift[63:31]) || (~|w_shift[63:31]));
        o_result.result_index = r_s3_index;
        o_result.overflow     = w_ovf;
        o_result.batch_done   = r_s3_bd;
        if (w_ovf) begin
            o_result.result_value = w_shift[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            o_result.result_value = w_shift[31:0];
        end
    end

    assign o_push     = r_s3_emit;
    assign o_inflight = 2'(r_s1_valid & r_s1_ctrl.emit) + 2'(r_s2_valid & r_s2_ctrl.emit)
                      + 2'(r_s3_emit);

    always_ff @(posedge i_clk) begin
        r_s1_ctrl  <= i_ctrl;
        r_s1_value <= i_value;
        r_s2_ctrl  <= r_s1_ctrl;
        r_s2_prod  <= r_s1_value * i_vec;
        r_s3_index <= r_s2_ctrl.index;
        r_s3_bd    <= r_s2_ctrl.batch_done;
        r_s3_res   <= w_res;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_emit  <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_emit  <= r_s2_valid & r_s2_ctrl.emit;
            r_acc      <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ===== design/csrspmv_ofifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_ofifo import csrspmv_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_out_item     i_data,
    input  wire logic          i_ready,
    output logic               o_valid,
    output t_out_item          o_data,
    output logic [OFIFO_PW:0]  o_count
);

    t_out_item           r_mem [OFIFO_DEPTH];
    logic [OFIFO_PW-1:0] r_wptr;
    logic [OFIFO_PW-1:0] r_rptr;
    logic [OFIFO_PW:0]   r_count;
    logic                w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
    assign w_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (OFIFO_PW + 1)'(i_push) - (OFIFO_PW + 1)'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ===== design/csr_sparse_matrix_vector_multiply_top.sv =====
// Sparse matrix times dense vector in Q16.16, one row result per closed row of the batch.
// Input channel (i_in_valid / o_in_ready, i_in_data) carries vector writes,
// matrix nonzeros and empty-row items; a transfer happens when both are high.
// Output channel (o_out_valid / i_out_ready, o_out_data) carries one result for
// each row of the batch that is closed by row_end or by an empty-row item.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
// to be used only while the block is idle; the block itself does not enforce it.
// Throughput is one item per cycle while input ready is high. After the transfer
// of the item that closes its row, a result passes through vector memory read,
// multiply, accumulate, then round and saturate into an eight-entry output queue.
// Input ready depends only on registers: it drops when queued plus in-flight
// results would exceed the queue, so a stalled receiver fills the queue and
// then holds off the sender without losing results.
// Reset clears the pipeline, the accumulator, the queue and the registers to
// first_row 0, row_limit 65536 and cols_in_use 1024. The vector memory is not
// cleared; entries must be written before they are used.
`timescale 1ns / 1ps
`default_nettype none

module csr_sparse_matrix_vector_multiply_top import csrspmv_pkg::*; #(
    parameter int unsigned VECTOR_DEPTH = DEF_VECTOR_DEPTH,
    parameter int unsigned MAX_ROWS     = DEF_MAX_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);

    localparam int unsigned VEC_AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam logic [24:0] MAX_ROWS_W = 25'(MAX_ROWS);

    logic [15:0] r_first_row;
    logic [16:0] r_row_limit;
    logic [10:0] r_cols_in_use;
    logic        r_rdy_en;

    logic                  w_accept;
    logic [16:0]           w_limit;
    logic                  w_in_batch;
    logic                  w_col_ok;
    logic [VEC_AW+9:0]     w_addr_ext;
    logic                  w_is_nz;
    logic                  w_is_wr;
    logic                  w_is_empty;
    t_ctrl                 w_ctrl;
    logic [31:0]           w_rdata;
    logic                  w_push;
    t_out_item             w_result;
    logic [1:0]            w_inflight;
    logic [OFIFO_PW:0]     w_count;
    logic [OFIFO_PW+1:0]   w_pending;

    always_comb begin
        w_limit    = (25'(r_row_limit) < MAX_ROWS_W) ? r_row_limit : 17'(MAX_ROWS);
        w_in_batch = (i_in_data.row_number >= r_first_row)
                   && (17'(i_in_data.row_number) < w_limit);
        w_col_ok   = 32'(i_in_data.column) < 32'(VECTOR_DEPTH);
        w_addr_ext = {{VEC_AW{1'b0}}, i_in_data.column};
        w_is_nz    = (i_in_data.command == CMD_NONZERO);
        w_is_wr    = (i_in_data.command == CMD_WRITE_VEC);
        w_is_empty = (i_in_data.command == CMD_EMPTY_ROW);

        w_ctrl.add        = w_is_nz && w_in_batch && w_col_ok
                          && (11'(i_in_data.column) < r_cols_in_use);
        w_ctrl.closes     = (w_is_nz && i_in_data.row_end) || w_is_empty;
        w_ctrl.is_nz      = w_is_nz;
        w_ctrl.emit       = w_ctrl.closes && w_in_batch;
        w_ctrl.index      = i_in_data.row_number - r_first_row;
        w_ctrl.batch_done = (w_limit != '0) && (17'(i_in_data.row_number) == w_limit - 1'b1);

        w_pending  = (OFIFO_PW + 2)'(w_count) + (OFIFO_PW + 2)'(w_inflight);
        o_in_ready = r_rdy_en && (w_pending < (OFIFO_PW + 2)'(OFIFO_DEPTH));
        w_accept   = i_in_valid & o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_row   <= '0;
            r_row_limit   <= 17'd65536;
            r_cols_in_use <= 11'd1024;
            r_rdy_en      <= 1'b0;
        end else begin
            r_rdy_en <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FIRST_ROW:   r_first_row   <= i_cfg_data[15:0];
                    REG_ROW_LIMIT:   r_row_limit   <= i_cfg_data;
                    REG_COLS_IN_USE: r_cols_in_use <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    csrspmv_vmem #(
        .VECTOR_DEPTH(VECTOR_DEPTH)
    ) u_vmem (
        .i_clk   (i_clk),
        .i_en    (w_accept && ((w_is_wr && w_col_ok) || w_is_nz)),
        .i_we    (w_is_wr),
        .i_addr  (w_addr_ext[VEC_AW-1:0]),
        .i_wdata (i_in_data.entry_value),
        .o_rdata (w_rdata)
    );

    csrspmv_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept && (w_is_nz || w_is_empty)),
        .i_ctrl     (w_ctrl),
        .i_value    (i_in_data.entry_value),
        .i_vec      (w_rdata),
        .o_push     (w_push),
        .o_result   (w_result),
        .o_inflight (w_inflight)
    );

    csrspmv_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_count (w_count)
    );

endmodule

`default_nettype wire

// ===== design/csrspmv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "csr_sparse_matrix_vector_multiply_top_assert.svh"

module csrspmv_checker import csrspmv_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire t_in_item    i_in_data,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_out_item   o_out_data
);

    `CSRSPMV_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    `CSRSPMV_ASSERT_NOW(a_ovf_saturated, o_out_valid && o_out_data.overflow, (o_out_data.result_value == 32'sh7fff_ffff) || (o_out_data.result_value == 32'sh8000_0000))

    `CSRSPMV_ASSERT_NOW(a_result_after_transfer, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 4) && ($past(i_in_data.command, 4) == CMD_NONZERO || $past(i_in_data.command, 4) == CMD_EMPTY_ROW))

endmodule

bind csr_sparse_matrix_vector_multiply_top csrspmv_checker u_csrspmv_checker (.*);

`default_nettype wire

// ===== tb/sv/csrspmv_row_checker.sv =====
`timescale 1ns / 1ps

module csrspmv_row_checker
    import csrspmv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_in_item    i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out_item   i_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_checked
);

    localparam logic signed [63:0] ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN    = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] RESULT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] RESULT_MIN = -64'sd2147483648;
    localparam logic signed [63:0] HALF_LSB   = 64'sd32768;

    logic signed [31:0] vector_copy [DEF_VECTOR_DEPTH];
    logic signed [63:0] row_sum;
    logic [15:0]        first_row_q;
    logic [16:0]        row_limit_q;
    logic [10:0]        cols_in_use_q;
    t_out_item          expected_rows[$];

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return ACC_MAX;
        if (a[63] && b[63] && !s[63]) return ACC_MIN;
        return s;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic predict_row_result(input t_in_item it);
        logic [16:0]        lim;
        logic               in_batch;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic signed [63:0] closed;
        logic signed [63:0] rounded;
        t_out_item          r;
        lim = (row_limit_q > 17'(DEF_MAX_ROWS)) ? 17'(DEF_MAX_ROWS) : row_limit_q;
        in_batch = (it.row_number >= first_row_q) && ({1'b0, it.row_number} < lim);
        case (it.command)
            CMD_WRITE_VEC: begin
                vector_copy[it.column] = it.entry_value;
                return;
            end
            CMD_NONE: return;
            CMD_NONZERO: begin
                if (in_batch && it.column < cols_in_use_q) begin
                    lhs = $signed(it.entry_value);
                    rhs = vector_copy[it.column];
                    row_sum = sat_sum(row_sum, lhs * rhs);
                end
                if (!it.row_end) return;
                closed = row_sum;
            end
            default: closed = '0;
        endcase
        row_sum = '0;
        if (!in_batch) return;
        rounded = sat_sum(closed, HALF_LSB) >>> 16;
        r.overflow = 1'b0;
        if (rounded > RESULT_MAX) begin
            rounded = RESULT_MAX;
            r.overflow = 1'b1;
        end else if (rounded < RESULT_MIN) begin
            rounded = RESULT_MIN;
            r.overflow = 1'b1;
        end
        r.result_index = it.row_number - first_row_q;
        r.result_value = rounded[31:0];
        r.batch_done = (lim != '0) && ({1'b0, it.row_number} == lim - 17'd1);
        expected_rows.push_back(r);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            expected_rows.delete();
            row_sum = '0;
            first_row_q = '0;
            row_limit_q = 17'(DEF_MAX_ROWS);
            cols_in_use_q = 11'(DEF_VECTOR_DEPTH);
            o_mismatches = 0;
            o_checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_rows.size() == 0) begin
                    report("result with no expectation", 64'(i_out_data), '0);
                end else begin
                    want = expected_rows.pop_front();
                    if (i_out_data.result_index !== want.result_index)
                        report("result_index", 64'(i_out_data.result_index),
                               64'(want.result_index));
                    if (i_out_data.result_value !== want.result_value)
                        report("result_value", 64'(i_out_data.result_value),
                               64'(want.result_value));
                    if (i_out_data.overflow !== want.overflow)
                        report("overflow", 64'(i_out_data.overflow), 64'(want.overflow));
                    if (i_out_data.batch_done !== want.batch_done)
                        report("batch_done", 64'(i_out_data.batch_done),
                               64'(want.batch_done));
                    o_checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FIRST_ROW:   first_row_q = i_cfg_data[15:0];
                    REG_ROW_LIMIT:   row_limit_q = i_cfg_data;
                    REG_COLS_IN_USE: cols_in_use_q = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_row_result(i_in_data);
        end
        o_pending = expected_rows.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import csrspmv_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_STALL   = 150;
    localparam int VEC_DEPTH    = DEF_VECTOR_DEPTH;
    localparam int ROW_SPAN     = DEF_MAX_ROWS;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_FIRST_ROW;
    logic [16:0] cfg_data = '0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_data;

    int mismatches;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent = 0;
    int settings_used = 0;
    int tx_gap_max = 4;
    int stall_req = 0;
    int stall_done = 0;

    int cur_first = 0;
    int cur_limit = ROW_SPAN;
    int cur_cols = VEC_DEPTH;
    bit vec_written[VEC_DEPTH];
    int written_cols[$];

    always #CLK_HALF clk = ~clk;

    csr_sparse_matrix_vector_multiply_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    csrspmv_row_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_in_item make_item(t_cmd cmd, int row, int col, logic [31:0] v, bit last);
        t_in_item it;
        it.command = cmd;
        it.row_number = row[15:0];
        it.column = col[9:0];
        it.entry_value = v;
        it.row_end = last;
        return it;
    endfunction

    function automatic int batch_end();
        return (cur_limit < ROW_SPAN) ? cur_limit : ROW_SPAN;
    endfunction

    function automatic bit row_in_batch(int row);
        return row >= cur_first && row < batch_end();
    endfunction

    function automatic int pick_row();
        if (batch_end() > cur_first && $urandom_range(0, 9) < 8)
            return $urandom_range(cur_first, batch_end() - 1);
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'h0000_0001;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r <= 2) return 32'($urandom_range(0, 1 << 18)) - 32'h0002_0000;
        return $urandom;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = (tx_gap_max == 0 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, tx_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (it.command != CMD_NONE) items_sent++;
    endtask

    task automatic write_vec(int col, logic [31:0] v);
        send_item(make_item(CMD_WRITE_VEC, $urandom_range(0, 65535), col, v,
                            1'($urandom_range(0, 1))));
        if (!vec_written[col]) begin
            vec_written[col] = 1'b1;
            written_cols.push_back(col);
        end
    endtask

    // Columns that the block adds into an in-batch row are always taken from written entries.
    task automatic send_row(int row, int count, bit close_row);
        int cols[$];
        int uniq[$];
        int c;
        bit reads;
        reads = row_in_batch(row);
        repeat (count) begin
            c = $urandom_range(0, VEC_DEPTH - 1);
            if ($urandom_range(0, 1) == 0 || (reads && c < cur_cols && !vec_written[c]))
                c = written_cols[$urandom_range(0, written_cols.size() - 1)];
            cols.push_back(c);
        end
        cols.sort();
        foreach (cols[i])
            if (i == 0 || cols[i] != cols[i - 1]) uniq.push_back(cols[i]);
        foreach (uniq[i])
            send_item(make_item(CMD_NONZERO, row, uniq[i], pick_value(),
                                close_row && i == uniq.size() - 1));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(int fr, int rl, int cols);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= REG_FIRST_ROW;
        cfg_data <= 17'(fr);
        @(posedge clk);
        cfg_index <= REG_ROW_LIMIT;
        cfg_data <= 17'(rl);
        @(posedge clk);
        cfg_index <= REG_COLS_IN_USE;
        cfg_data <= 17'(cols);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_first = fr;
        cur_limit = rl;
        cur_cols = cols;
        settings_used++;
    endtask

    task automatic run_phase(int count, int gap_max, bit hold_receiver, bit pause_sender);
        int start;
        int choice;
        bit mid_done;
        start = items_sent;
        mid_done = 1'b0;
        tx_gap_max = gap_max;
        while (items_sent - start < count) begin
            if (!mid_done && items_sent - start >= count / 2) begin
                mid_done = 1'b1;
                if (hold_receiver) stall_req++;
                if (pause_sender) wait_drained();
            end
            choice = $urandom_range(0, 99);
            if (choice < 8) begin
                write_vec($urandom_range(0, VEC_DEPTH - 1), pick_value());
            end else if (choice < 68) begin
                send_row(pick_row(), ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40)
                                                                  : $urandom_range(1, 6), 1'b1);
            end else if (choice < 80) begin
                send_item(make_item(CMD_EMPTY_ROW, pick_row(), $urandom_range(0, 1023),
                                    $urandom, 1'($urandom_range(0, 1))));
            end else if (choice < 86) begin
                send_item(make_item(CMD_NONE, $urandom_range(0, 65535), $urandom_range(0, 1023),
                                    $urandom, 1'($urandom_range(0, 1))));
            end else begin
                // A row left open is discarded by the empty-row item that follows.
                send_row(pick_row(), $urandom_range(1, 3), 1'b0);
                send_item(make_item(CMD_EMPTY_ROW, pick_row(), $urandom_range(0, 1023),
                                    $urandom, 1'($urandom_range(0, 1))));
            end
        end
    endtask

    initial begin : receiver
        int gap;
        int rx_gap_max;
        int served;
        rx_gap_max = 12;
        served = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (stall_done < stall_req) begin
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_done++;
            end
            gap = (rx_gap_max == 0 || $urandom_range(0, 2) == 0) ? 0
                                                                : $urandom_range(1, rx_gap_max);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            served++;
            if (served % 32 == 0) rx_gap_max = $urandom_range(0, 1) ? 12 : 0;
        end
    end

    initial begin : stimulus
        int fr;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_vec(0, 32'h8000_0000);
        write_vec(1, 32'h8000_0000);
        write_vec(4, 32'h8000_0000);
        write_vec(2, 32'h7FFF_FFFF);
        write_vec(3, 32'h0000_0001);
        write_vec(1023, 32'h0001_0000);
        send_item(make_item(CMD_NONZERO, 0, 0, 32'h8000_0000, 1'b0));
        send_item(make_item(CMD_NONZERO, 0, 1, 32'h8000_0000, 1'b1));
        send_item(make_item(CMD_NONZERO, 1, 0, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(CMD_NONZERO, 1, 1, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(CMD_NONZERO, 1, 4, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(CMD_NONZERO, 2, 3, 32'h0000_8000, 1'b1));
        send_item(make_item(CMD_NONZERO, 3, 3, 32'hFFFF_8000, 1'b1));
        send_item(make_item(CMD_NONZERO, 4, 1023, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(CMD_NONZERO, 5, 2, 32'h1234_5678, 1'b0));
        send_item(make_item(CMD_EMPTY_ROW, 5, 0, 32'h0, 1'b0));
        send_item(make_item(CMD_NONE, 65535, 1023, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(CMD_EMPTY_ROW, 65535, 1023, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(CMD_NONZERO, 6, 2, 32'h8000_0000, 1'b1));

        write_config(10, 12, 2);
        send_item(make_item(CMD_NONZERO, 10, 3, 32'h0001_0000, 1'b1));
        send_item(make_item(CMD_NONZERO, 11, 0, 32'h0001_0000, 1'b1));
        send_item(make_item(CMD_NONZERO, 9, 0, 32'h0001_0000, 1'b1));
        send_item(make_item(CMD_EMPTY_ROW, 12, 0, 32'h0, 1'b1));

        write_config(5, 5, 1024);
        send_item(make_item(CMD_NONZERO, 5, 0, 32'h0001_0000, 1'b1));
        send_item(make_item(CMD_EMPTY_ROW, 4, 0, 32'h0, 1'b0));

        write_config(0, ROW_SPAN, VEC_DEPTH);
        tx_gap_max = 12;
        repeat (48) write_vec($urandom_range(0, VEC_DEPTH - 1), pick_value());
        run_phase(200, 12, 1'b1, 1'b0);

        write_config(65535, ROW_SPAN, VEC_DEPTH);
        run_phase(120, 0, 1'b0, 1'b0);

        write_config(0, 0, 0);
        run_phase(40, 12, 1'b0, 1'b0);

        fr = $urandom_range(0, 2000);
        write_config(fr, fr + $urandom_range(1, 3000), $urandom_range(1, VEC_DEPTH));
        run_phase(200, 12, 1'b0, 1'b1);

        write_config(0, ROW_SPAN, 0);
        run_phase(120, 0, 1'b0, 1'b0);

        write_config(60000, ROW_SPAN, 512);
        run_phase(200, 12, 1'b1, 1'b0);

        fr = $urandom_range(0, 65535);
        write_config(fr, $urandom_range(fr + 1, ROW_SPAN), $urandom_range(0, VEC_DEPTH));
        run_phase(200, 0, 1'b0, 1'b1);

        write_config(0, ROW_SPAN, VEC_DEPTH);
        run_phase(200, 12, 1'b1, 1'b0);

        wait_drained();
        $display("Sent %0d vector and matrix transfers under %0d register settings.",
                 items_sent, settings_used);
        $display("Compared %0d row results, with %0d long receiver hold-offs.",
                 checked, stall_done);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
